/* rtl/nearest_direction_classifier_top_defines.svh */
// Assertion macros for the nearest direction classifier.
// Included by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef NEAREST_DIRECTION_CLASSIFIER_TOP_DEFINES_SVH
`define NEAREST_DIRECTION_CLASSIFIER_TOP_DEFINES_SVH
`ifndef SYNTH
// Plain property check, sampled on clk_i, off during reset
`define NDC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ndc check failed");
// Implication check: when ante holds, cons holds in the same cycle
`define NDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ndc implication failed");
`else
`define NDC_ASSERT(lbl, prop)
`define NDC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

/* rtl/ndc_pkg.sv */
// Shared types and constants for the nearest direction classifier.
// No dependencies; imported by ndc_arith and nearest_direction_classifier_top.
package ndc_pkg;

  // Direction table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  // Dot product of two 16-bit triples: three 31-bit magnitudes summed
  localparam int DOT_W       = 33;

  // Request operation codes
  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd2;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec3_t;

  typedef struct packed {
    logic               operation;
    logic [4:0]         entry_index;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ndc_in_t;

  typedef struct packed {
    logic       found;
    logic [4:0] domain_index;
  } ndc_out_t;

  // Second operand of the dot unit
  typedef enum logic [0:0] {
    DS_VEC = 1'b0,
    DS_DIR = 1'b1
  } dot_src_e;

  // Operand pair of the shared 32x32 multiplier
  typedef enum logic [1:0] {
    MS_MAG = 2'd0,  // min_magnitude squared
    MS_THR = 2'd1,  // threshold squared
    MS_TS  = 2'd2,  // threshold squared times vector length squared
    MS_DOT = 2'd3   // dot product squared
  } mul_sel_e;

  typedef struct packed {
    logic     dot_en;
    dot_src_e dot_src;
    logic     mul_en;
    mul_sel_e mul_sel;
  } arith_ctrl_t;

endpackage

/* rtl/ndc_arith.sv */
// Shared arithmetic unit: a three-lane dot product and one 32x32 multiplier,
// both with registered results. Depends on ndc_pkg.
module ndc_arith import ndc_pkg::*; (
  input  logic                    clk_i,
  input  arith_ctrl_t             ctrl_i,
  input  vec3_t                   vec_i,
  input  vec3_t                   dir_i,
  input  logic [15:0]             min_mag_i,
  input  logic signed [15:0]      cos_thr_i,
  input  logic [31:0]             s_i,
  output logic signed [DOT_W-1:0] dot_o,
  output logic [63:0]             prod_o
);

  logic signed [15:0]      bx, by, bz;
  logic signed [31:0]      px, py, pz;
  logic signed [DOT_W-1:0] sum;
  logic signed [DOT_W-1:0] dot_q;
  logic signed [DOT_W-1:0] dot_neg;
  logic [31:0]             dot_mag;
  logic [15:0]             thr_mag;
  logic [31:0]             ma, mb;
  logic [63:0]             prod_q;

  // Dot lanes: vector with itself (length squared) or with a table entry
  always_comb begin
    if (ctrl_i.dot_src == DS_DIR) begin
      bx = dir_i.x;
      by = dir_i.y;
      bz = dir_i.z;
    end else begin
      bx = vec_i.x;
      by = vec_i.y;
      bz = vec_i.z;
    end
  end

  assign px  = vec_i.x * bx;
  assign py  = vec_i.y * by;
  assign pz  = vec_i.z * bz;
  assign sum = signed'({px[31], px}) + signed'({py[31], py}) + signed'({pz[31], pz});

  // Magnitudes; |d| stays below 2^32, |t| fits 16 bits unsigned
  assign dot_neg = -dot_q;
  assign dot_mag = dot_q[DOT_W-1] ? dot_neg[31:0] : dot_q[31:0];
  assign thr_mag = cos_thr_i[15] ? (~cos_thr_i + 16'sd1) : cos_thr_i;

  // Multiplier operand select
  always_comb begin
    unique case (ctrl_i.mul_sel)
      MS_MAG: begin
        ma = {16'b0, min_mag_i};
        mb = {16'b0, min_mag_i};
      end
      MS_THR: begin
        ma = {16'b0, thr_mag};
        mb = {16'b0, thr_mag};
      end
      MS_TS: begin
        ma = prod_q[31:0];
        mb = s_i;
      end
      MS_DOT: begin
        ma = dot_mag;
        mb = dot_mag;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.dot_en) begin
      dot_q <= sum;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= ma * mb;
    end
  end

  assign dot_o  = dot_q;
  assign prod_o = prod_q;

endmodule

/* rtl/nearest_direction_classifier_top.sv */
// Nearest direction classifier: direction table, sequencer and winner tracking.
// Depends on ndc_pkg, ndc_arith and nearest_direction_classifier_top_defines.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   in      | to block  | in_valid_i / in_stall_o   | ndc_in_t in_data_i
//   out     | from block| out_valid_o / out_stall_i | ndc_out_t out_data_o
//   cfg     | to block  | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// A write request leaves the block idle for the next request. A classify request passes
// setup states SQR, TSQ, THR and LIM (the first three on the shared multiplier), then
// one table entry per cycle, n = min(entries_in_use, 32) in all, goes through a four-stage
// read/dot/square/select pipeline, set by the single table read port; its result is then
// registered. With n = 0 nothing is scanned, and a too-short vector skips LIM and the scan.
// Reset clears control and configuration; the table is undefined until written.
// A waiting result does not block new requests; a finished classify waits for the
// output register to empty.
`include "nearest_direction_classifier_top_defines.svh"
module nearest_direction_classifier_top import ndc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ndc_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ndc_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SQR  = 7'b0000010,
    ST_TSQ  = 7'b0000100,
    ST_THR  = 7'b0001000,
    ST_LIM  = 7'b0010000,
    ST_SCAN = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [15:0]        min_mag_q;
  logic signed [15:0] cos_thr_q;
  logic [5:0]         entries_q;

  // Table
  vec3_t mem [TABLE_DEPTH];
  vec3_t rd_q;

  // Per-request state
  vec3_t                   vec_q;
  logic [CNT_W-1:0]        n_q;
  logic [CNT_W-1:0]        idx_q;
  logic [31:0]             s_q;
  logic                    mag_ok_q;
  logic [63:0]             thr_q;
  logic                    found_q;
  logic [IDX_W-1:0]        best_q;
  logic signed [DOT_W-1:0] best_d_q;
  logic                    best_sat_q;

  // Scan pipeline
  logic                    p1_vld_q, p2_vld_q, p3_vld_q;
  logic [IDX_W-1:0]        p1_idx_q, p2_idx_q, p3_idx_q;
  logic signed [DOT_W-1:0] d3_q;

  // Output register
  logic     out_vld_q;
  ndc_out_t out_q;

  arith_ctrl_t             actrl;
  logic signed [DOT_W-1:0] dot;
  logic [63:0]             prod;

  logic             in_acc;
  logic             classify;
  logic             issue;
  logic             scan_done;
  logic             out_free;
  logic [CNT_W-1:0] n_new;
  logic [63:0]      thr_floor;
  logic [63:0]      lim;
  logic             t_nonneg;
  logic             d_pos;
  logic             qual;
  logic             better;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign classify   = (in_data_i.operation == OP_CLASSIFY);
  assign issue      = (state_q == ST_SCAN) && (idx_q < n_q);
  assign scan_done  = !issue && !p1_vld_q && !p2_vld_q && !p3_vld_q;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign n_new      = (entries_q > 6'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                    : CNT_W'(entries_q);

  // Shared arithmetic
  always_comb begin
    actrl.dot_en  = 1'b0;
    actrl.dot_src = DS_VEC;
    actrl.mul_en  = 1'b0;
    actrl.mul_sel = MS_MAG;
    unique case (state_q)
      ST_SQR: begin
        actrl.dot_en  = 1'b1;
        actrl.mul_en  = 1'b1;
      end
      ST_TSQ: begin
        actrl.mul_en  = 1'b1;
        actrl.mul_sel = MS_THR;
      end
      ST_THR: begin
        actrl.mul_en  = mag_ok_q;
        actrl.mul_sel = MS_TS;
      end
      ST_SCAN: begin
        actrl.dot_en  = p1_vld_q;
        actrl.dot_src = DS_DIR;
        actrl.mul_en  = p2_vld_q;
        actrl.mul_sel = MS_DOT;
      end
      default: ;
    endcase
  end

  ndc_arith u_arith (
    .clk_i     (clk_i),
    .ctrl_i    (actrl),
    .vec_i     (vec_q),
    .dir_i     (rd_q),
    .min_mag_i (min_mag_q),
    .cos_thr_i (cos_thr_q),
    .s_i       (s_q),
    .dot_o     (dot),
    .prod_o    (prod)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && classify) state_d = ST_SQR;
      ST_SQR:  state_d = ST_TSQ;
      ST_TSQ:  state_d = ST_THR;
      ST_THR:  state_d = mag_ok_q ? ST_LIM : ST_FIN;
      ST_LIM:  state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Threshold test: 4*d^2 against t^2*s, folded into one compare value
  assign thr_floor = {2'b00, prod[63:2]};
  assign lim       = {4'b0, s_q, 28'b0};
  assign t_nonneg  = !cos_thr_q[15];
  assign d_pos     = !d3_q[DOT_W-1] && (d3_q != '0);
  assign qual      = t_nonneg ? (d_pos && (prod > thr_q))
                              : (!d3_q[DOT_W-1] || (prod < thr_q));
  assign better    = !found_q || (!best_sat_q && (d3_q > best_d_q));

  // Table write and read port
  always_ff @(posedge clk_i) begin
    if (in_acc && !classify) begin
      mem[in_data_i.entry_index] <= {in_data_i.dir_x, in_data_i.dir_y, in_data_i.dir_z};
    end
    if (issue) begin
      rd_q <= mem[idx_q[IDX_W-1:0]];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mag_q <= '0;
      cos_thr_q <= '0;
      entries_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_MAG: min_mag_q <= cfg_data_i;
        CFG_COS_THR: cos_thr_q <= cfg_data_i;
        CFG_ENTRIES: entries_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      p1_vld_q <= issue;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      if (in_acc && classify) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (issue) idx_q <= idx_q + CNT_W'(1);
        if (p3_vld_q && qual && better) found_q <= 1'b1;
      end
      if (state_q == ST_FIN && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && classify) begin
      vec_q <= {in_data_i.vec_x, in_data_i.vec_y, in_data_i.vec_z};
      n_q   <= n_new;
    end
    if (state_q == ST_TSQ) begin
      s_q      <= dot[31:0];
      mag_ok_q <= dot[31:0] > prod[31:0];
    end
    if (state_q == ST_LIM) begin
      thr_q <= t_nonneg ? thr_floor : (thr_floor + 64'(|prod[1:0]));
    end
    p1_idx_q <= idx_q[IDX_W-1:0];
    p2_idx_q <= p1_idx_q;
    p3_idx_q <= p2_idx_q;
    if (p2_vld_q) d3_q <= dot;
    // Winner update
    if (p3_vld_q && qual && better) begin
      best_q     <= p3_idx_q;
      best_d_q   <= d3_q;
      best_sat_q <= d_pos && (prod >= lim);
    end
    if (state_q == ST_FIN && out_free) begin
      out_q.found        <= found_q;
      out_q.domain_index <= found_q ? 5'(best_q) : 5'd0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  `NDC_ASSERT_IMP(a_pipe_in_scan, p1_vld_q || p2_vld_q || p3_vld_q, state_q == ST_SCAN)
  `NDC_ASSERT_IMP(a_idx_bound, state_q == ST_SCAN, idx_q <= n_q)
  `NDC_ASSERT_IMP(a_best_bound, (state_q == ST_SCAN) && found_q, CNT_W'(best_q) < n_q)
  `NDC_ASSERT_IMP(a_fin_loads, (state_q == ST_IDLE) && $past(state_q == ST_FIN), out_vld_q)
  `NDC_ASSERT_IMP(a_miss_zero, out_vld_q && !out_q.found, out_q.domain_index == 5'd0)

endmodule

/* verif/testbench.sv */
// Testbench for nearest_direction_classifier_top: loads the direction table, classifies
// vectors and checks every result against a cycle-free predictor kept in this file.
// Depends on ndc_pkg and the classifier RTL only.
`timescale 1ns / 100ps

module testbench;
  import ndc_pkg::*;

  localparam int ONE_Q14         = 16384;
  localparam int MAX_GAP         = 16;
  localparam int SETTLE_CYCLES   = 48;   // longest classify plus output register
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int REPORT_LIMIT    = 10;
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 55;

  // DUT connections
  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  ndc_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  ndc_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [15:0]          cfg_data;

  // Shadow of the block's registers and direction table
  logic [15:0]        min_mag_cfg = '0;
  logic signed [15:0] cos_thr_cfg = '0;
  logic [5:0]         entries_cfg = '0;
  vec3_t              dir_tab    [TABLE_DEPTH];
  bit                 dir_loaded [TABLE_DEPTH];

  // Pending classify results, oldest first
  ndc_out_t domain_q [$];

  // Idling controls
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_wait = 0;
  int rx_hold_left = 0;

  // Bookkeeping
  int error_count = 0;
  int results_checked = 0;
  int writes_sent = 0;
  int classifies_sent = 0;
  int settings_applied = 0;
  int idle_cycles = 0;

  nearest_direction_classifier_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Exact test of cos > thr / 2^15, i.e. 2*d > thr * sqrt(s), squares only
  function automatic bit cos_passes(longint d, longint unsigned s);
    longint thr;
    longint unsigned dm, tm, lhs, rhs;
    thr = cos_thr_cfg;
    dm  = (d < 0) ? -d : d;
    tm  = (thr < 0) ? -thr : thr;
    lhs = dm * dm;
    rhs = tm * tm * s;
    if (thr >= 0) return (d > 0) && (lhs > rhs / 4);
    return (d >= 0) || (lhs < (rhs + 3) / 4);
  endfunction

  // Best direction for one classify request under the current table and registers
  function automatic ndc_out_t predict_domain(ndc_in_t req);
    longint vx, vy, vz, d, best_d;
    longint unsigned s, lim, mm, dm;
    int span, best;
    bit hit, best_sat;
    ndc_out_t r;
    vx = $signed(req.vec_x);
    vy = $signed(req.vec_y);
    vz = $signed(req.vec_z);
    s  = vx * vx + vy * vy + vz * vz;
    mm = min_mag_cfg;
    hit = 1'b0;
    best = 0;
    best_d = 0;
    best_sat = 1'b0;
    if (s > mm * mm) begin
      span = (entries_cfg < TABLE_DEPTH) ? entries_cfg : TABLE_DEPTH;
      lim  = s << 28;  // (|v| * 2^14)^2
      for (int i = 0; i < span; i++) begin
        d = vx * $signed(dir_tab[i].x) + vy * $signed(dir_tab[i].y)
          + vz * $signed(dir_tab[i].z);
        if (!cos_passes(d, s)) continue;
        // a cosine at or above one is final: lowest such index keeps the win
        if (!hit || (!best_sat && d > best_d)) begin
          dm = (d < 0) ? -d : d;
          hit = 1'b1;
          best = i;
          best_d = d;
          best_sat = (d > 0) && (dm * dm >= lim);
        end
      end
    end
    r.found        = hit;
    r.domain_index = hit ? 5'(best) : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic vec3_t vec3(int x, int y, int z);
    vec3_t v;
    v.x = 16'(x);
    v.y = 16'(y);
    v.z = 16'(z);
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  // Unused fields carry random bits
  function automatic ndc_in_t filler_request();
    ndc_in_t r;
    r.operation   = OP_CLASSIFY;
    r.entry_index = 5'($urandom);
    r.vec_x = 16'($urandom);
    r.vec_y = 16'($urandom);
    r.vec_z = 16'($urandom);
    r.dir_x = 16'($urandom);
    r.dir_y = 16'($urandom);
    r.dir_z = 16'($urandom);
    return r;
  endfunction

  function automatic ndc_in_t write_request(int idx, vec3_t d);
    ndc_in_t r;
    r = filler_request();
    r.operation   = OP_WRITE;
    r.entry_index = 5'(idx);
    r.dir_x = d.x;
    r.dir_y = d.y;
    r.dir_z = d.z;
    return r;
  endfunction

  function automatic ndc_in_t classify_request(vec3_t v);
    ndc_in_t r;
    r = filler_request();
    r.operation = OP_CLASSIFY;
    r.vec_x = v.x;
    r.vec_y = v.y;
    r.vec_z = v.z;
    return r;
  endfunction

  // Mostly unit directions; some axes, copies (ties), oversized ones and raw bits
  function automatic vec3_t random_direction();
    real a, b, c, len;
    int pick, src, sgn, ax;
    vec3_t unit;
    a = real'($urandom_range(0, 2000)) - 1000.0;
    b = real'($urandom_range(0, 2000)) - 1000.0;
    c = real'($urandom_range(0, 2000)) - 1000.0;
    len = $sqrt(a * a + b * b + c * c);
    if (len < 1.0) begin
      a = 1.0;
      len = 1.0;
    end
    unit = vec3(int'(a / len * ONE_Q14), int'(b / len * ONE_Q14), int'(c / len * ONE_Q14));
    pick = $urandom_range(0, 9);
    src  = $urandom_range(0, TABLE_DEPTH - 1);
    sgn  = $urandom_range(0, 1) ? ONE_Q14 : -ONE_Q14;
    ax   = $urandom_range(0, 2);
    case (pick)
      0: return vec3($urandom, $urandom, $urandom);
      1: return vec3(ax == 0 ? sgn : 0, ax == 1 ? sgn : 0, ax == 2 ? sgn : 0);
      2: return dir_loaded[src] ? dir_tab[src] : unit;
      3: return vec3(sat16(2 * unit.x), sat16(2 * unit.y), sat16(2 * unit.z));
      default: return unit;
    endcase
  endfunction

  // One component of a vector pointed near a table direction
  function automatic logic signed [15:0] aim(logic signed [15:0] c, int scale, int nz);
    int jitter;
    jitter = $urandom_range(0, 2 * nz);
    return sat16(int'($signed(c)) * scale / ONE_Q14 + jitter - nz);
  endfunction

  // Classify vectors: mostly aimed at a searched entry, some edge, tiny and random ones
  function automatic vec3_t probe_vector(int span);
    int edges [5];
    int pick, idx, scale, nz;
    vec3_t base;
    edges = '{-32768, 32767, 0, -1, 1};
    pick  = $urandom_range(0, 9);
    if (pick == 0) return vec3($urandom, $urandom, $urandom);
    if (pick == 1)
      return vec3(edges[$urandom_range(0, 4)], edges[$urandom_range(0, 4)],
                  edges[$urandom_range(0, 4)]);
    if (pick == 2)
      return vec3(int'($urandom_range(0, 6)) - 3, int'($urandom_range(0, 6)) - 3,
                  int'($urandom_range(0, 6)) - 3);
    idx   = $urandom_range(0, (span > 0 ? span : TABLE_DEPTH) - 1);
    base  = dir_loaded[idx] ? dir_tab[idx] : vec3(ONE_Q14, 0, 0);
    scale = $urandom_range(1, 1 << $urandom_range(1, 15));
    nz    = scale >> $urandom_range(2, 8);
    return vec3(aim(base.x, scale, nz), aim(base.y, scale, nz), aim(base.z, scale, nz));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one request after a random gap and record its effect once accepted
  task automatic send_request(input ndc_in_t req);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (req.operation == OP_WRITE) begin
      dir_tab[req.entry_index]    = vec3(req.dir_x, req.dir_y, req.dir_z);
      dir_loaded[req.entry_index] = 1'b1;
      writes_sent++;
    end else begin
      domain_q.push_back(predict_domain(req));
      classifies_sent++;
    end
  endtask

  // Drop valid, wait for all results, then let a trailing table write finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (domain_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_MAG: min_mag_cfg = value;
      CFG_COS_THR: cos_thr_cfg = value;
      CFG_ENTRIES: entries_cfg = value[5:0];
      default: ;
    endcase
  endtask

  // Register writes only with the block idle; entry count gets junk upper bits
  task automatic apply_settings(input int min_mag, input int thr, input int entries);
    wait_idle();
    write_register(CFG_MIN_MAG, 16'(min_mag));
    write_register(CFG_COS_THR, 16'(thr));
    write_register(CFG_ENTRIES, {10'($urandom), 6'(entries)});
    settings_applied++;
  endtask

  // Receiver: per-result wait, plus a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check and watchdog
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : result_check
    ndc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (domain_q.size() == 0) begin
        note_failure($sformatf("unexpected result found=%0b domain=%0d",
                               out_data.found, out_data.domain_index));
      end else begin
        want = domain_q.pop_front();
        if (want.found !== out_data.found || want.domain_index !== out_data.domain_index)
          note_failure($sformatf(
              "result %0d: expected found=%0b domain=%0d, got found=%0b domain=%0d",
              results_checked, want.found, want.domain_index,
              out_data.found, out_data.domain_index));
      end
      results_checked++;
      rx_wait = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    end
  end

  // Ends the run when no request or result moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers search no entry: nothing is ever found
  task automatic test_empty_table();
    send_request(classify_request(vec3(0, 0, 0)));
    send_request(classify_request(vec3(-32768, -32768, -32768)));
    send_request(classify_request(vec3(32767, 32767, 32767)));
  endtask

  // Hand-built table: axes, a duplicate for ties, an oversized entry, a diagonal
  task automatic test_directed_table();
    send_request(write_request(0, vec3(32767, 0, 0)));       // cosine above one
    send_request(write_request(1, vec3(ONE_Q14, 0, 0)));
    send_request(write_request(2, vec3(0, ONE_Q14, 0)));
    send_request(write_request(3, vec3(0, -ONE_Q14, 0)));
    send_request(write_request(4, vec3(0, 0, ONE_Q14)));
    send_request(write_request(5, vec3(0, 0, -ONE_Q14)));
    send_request(write_request(6, vec3(0, ONE_Q14, 0)));     // same as entry 2
    send_request(write_request(7, vec3(11585, 11585, 0)));
    apply_settings(0, 0, 8);
    send_request(classify_request(vec3(100, 3, 0)));
    send_request(classify_request(vec3(0, 500, 0)));
    send_request(classify_request(vec3(-32768, -32768, -32768)));
    send_request(classify_request(vec3(32767, 32767, 32767)));
    send_request(classify_request(vec3(0, 0, 0)));
    // tightest threshold: only an exact match passes
    apply_settings(0, 32767, 8);
    send_request(classify_request(vec3(0, 0, -7)));
    send_request(classify_request(vec3(3, 4, 0)));
    // loosest threshold: all but exactly opposite directions pass
    apply_settings(0, -32768, 8);
    send_request(classify_request(vec3(0, -1, 0)));
    send_request(classify_request(vec3(-5, 0, 0)));
    // largest minimum length: no vector is long enough
    apply_settings(65535, 0, 8);
    send_request(classify_request(vec3(32767, 32767, 32767)));
    // length exactly at and just above the minimum
    apply_settings(1000, 0, 8);
    send_request(classify_request(vec3(1000, 0, 0)));
    send_request(classify_request(vec3(0, -1001, 0)));
  endtask

  // Random table traffic over many register settings
  task automatic test_random_settings();
    int entries, thr, min_mag, span;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (!dir_loaded[i]) send_request(write_request(i, random_direction()));
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 4))
        0: entries = 0;
        1: entries = 1;
        2: entries = TABLE_DEPTH;
        3: entries = $urandom_range(TABLE_DEPTH + 1, 63);
        default: entries = $urandom_range(2, TABLE_DEPTH - 1);
      endcase
      case ($urandom_range(0, 5))
        0: thr = -32768;
        1: thr = 32767;
        2: thr = 0;
        3: thr = int'($signed(16'($urandom)));
        default: thr = $urandom_range(20000, 32700);
      endcase
      case ($urandom_range(0, 5))
        0: min_mag = $urandom_range(0, 65535);
        1: min_mag = $urandom_range(0, 200);
        default: min_mag = 0;
      endcase
      // open with the extreme corners
      if (p == 0) begin
        entries = 63;
        thr = -32768;
        min_mag = 0;
      end else if (p == 1) begin
        entries = TABLE_DEPTH;
        thr = 32767;
        min_mag = 65535;
      end
      apply_settings(min_mag, thr, entries);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      span = (entries_cfg < TABLE_DEPTH) ? entries_cfg : TABLE_DEPTH;
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 2)
          send_request(write_request($urandom_range(0, TABLE_DEPTH - 1), random_direction()));
        else
          send_request(classify_request(probe_vector(span)));
      end
    end
  endtask

  // Receiver holds off while requests keep coming, so the block stalls its input
  task automatic test_output_backpressure();
    apply_settings(0, 30000, TABLE_DEPTH);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    @(posedge clk);
    rx_hold_left = HOLD_CYCLES;
    repeat (24) send_request(classify_request(probe_vector(TABLE_DEPTH)));
    wait_idle();
  endtask

  // Bursts with the sender pausing until every result is back
  task automatic test_drain_between_bursts();
    apply_settings($urandom_range(0, 100), $urandom_range(25000, 32000), TABLE_DEPTH);
    rx_idle_on = 1'b1;
    repeat (4) begin
      tx_idle_on = $urandom_range(0, 1);
      repeat (15) begin
        if ($urandom_range(0, 4) == 0)
          send_request(write_request($urandom_range(0, TABLE_DEPTH - 1), random_direction()));
        else
          send_request(classify_request(probe_vector(TABLE_DEPTH)));
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_MIN_MAG;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_directed_table();
    test_random_settings();
    test_output_backpressure();
    test_drain_between_bursts();
    wait_idle();

    $display("Ran %0d table writes and %0d classifies over %0d register settings,",
             writes_sent, classifies_sent, settings_applied);
    $display("with output hold-off and drained bursts; %0d results checked, %0d errors.",
             results_checked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* nearest_direction_classifier_top.f */
+incdir+rtl
rtl/ndc_pkg.sv
rtl/ndc_arith.sv
rtl/nearest_direction_classifier_top.sv
verif/testbench.sv
